>>> rtl/core/lc3_instruction_execute_macros.svh
// Assertion macros shared by the execute block.
`ifndef LC3_INSTRUCTION_EXECUTE_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define LC3_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define LC3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lc3_pkg.sv
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types, opcodes and helpers of the LC-3 execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lc3_pkg;

  localparam int unsigned MemAddrBitsDefault = 16;

  // Input modes.
  localparam logic [1:0] ModeMemWrite = 2'd0;
  localparam logic [1:0] ModeExec     = 2'd1;
  localparam logic [1:0] ModeRegWrite = 2'd2;
  localparam logic [1:0] ModeMemRead  = 2'd3;

  // Result status codes.
  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusIllegal = 2'd1;
  localparam logic [1:0] StatusTrap    = 2'd2;

  // Opcodes.
  localparam logic [3:0] OpBr   = 4'h0;
  localparam logic [3:0] OpAdd  = 4'h1;
  localparam logic [3:0] OpLd   = 4'h2;
  localparam logic [3:0] OpSt   = 4'h3;
  localparam logic [3:0] OpJsr  = 4'h4;
  localparam logic [3:0] OpAnd  = 4'h5;
  localparam logic [3:0] OpLdr  = 4'h6;
  localparam logic [3:0] OpStr  = 4'h7;
  localparam logic [3:0] OpRti  = 4'h8;
  localparam logic [3:0] OpNot  = 4'h9;
  localparam logic [3:0] OpLdi  = 4'hA;
  localparam logic [3:0] OpSti  = 4'hB;
  localparam logic [3:0] OpJmp  = 4'hC;
  localparam logic [3:0] OpRes  = 4'hD;
  localparam logic [3:0] OpLea  = 4'hE;
  localparam logic [3:0] OpTrap = 4'hF;

  // Operations of the shared ALU.
  localparam logic [1:0] AluAdd  = 2'd0;
  localparam logic [1:0] AluAnd  = 2'd1;
  localparam logic [1:0] AluNot  = 2'd2;
  localparam logic [1:0] AluPass = 2'd3;

  // Register index that selects the PC in a register write.
  localparam logic [3:0] RegIndexPc = 4'd8;
  localparam logic [2:0] CondZero   = 3'b010;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] instruction;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [3:0]  reg_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        dest_valid;
    logic [2:0]  dest_index;
    logic [15:0] dest_value;
    logic [2:0]  cond_flags;
    logic [15:0] next_pc;
    logic        mem_write_valid;
    logic [15:0] mem_write_addr;
    logic [15:0] mem_write_data;
    logic [7:0]  trap_vector;
    logic [15:0] read_data;
  } out_word_t;

  // Condition code of a written value.
  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v[15]) f = 3'b100;
    else if (v == 16'd0) f = 3'b010;
    else f = 3'b001;
    return f;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lc3_if.sv
// ----------------------------------------------------------------------------
// lc3_in_if / lc3_out_if
// Valid-ready channels that carry input and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lc3_in_if import lc3_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lc3_out_if import lc3_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lc3_instruction_execute.sv
// ----------------------------------------------------------------------------
// lc3_instruction_execute
// LC-3 execute block with registers, PC, condition code and word memory.
// ----------------------------------------------------------------------------
// Channel  Dir  Carries
// in_if    in   mode, instruction, address, write_data, reg_index
// out_if   out  status, register write, flags, PC, store, trap, read data
//
// A word is accepted in idle; execute, finish and the output register follow.
// A memory read adds StWait2; LD, LDR and STI add StRead1 and StWait1; LDI adds
// StRead1, StWait1, StRead2 and StWait2, since the single port of the word
// memory registers its read data. The next word is taken only after the result
// has been taken, so a receiver stall holds off the next word. Reset is
// asynchronous and clears control state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lc3_instruction_execute_macros.svh"

module lc3_instruction_execute import lc3_pkg::*; #(
  parameter int unsigned MemAddrBits = MemAddrBitsDefault
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  lc3_in_if.sink    in_if,
  lc3_out_if.source out_if
);

  typedef enum logic [2:0] {
    StIdle, StExec, StRead1, StWait1, StRead2, StWait2, StFinish, StOut
  } state_e;

  state_e      state_q;
  in_word_t    in_q;
  out_word_t   res_q;
  logic [15:0] regs_q [8];
  logic [15:0] pc_q;
  logic [2:0]  cc_q;
  logic [15:0] addr_q;

  // Memory port.
  logic                   mem_we;
  logic [MemAddrBits-1:0] mem_addr;
  logic [15:0]            mem_wdata;
  logic [15:0]            mem_rdata;

  lc3_mem #(.MemAddrBits(MemAddrBits)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Decode fields of the held word.
  logic [3:0]  op;
  logic [15:0] off9, off6, off11, imm5, src2, r6v, r9v;
  assign op    = in_q.instruction[15:12];
  assign off9  = {{7{in_q.instruction[8]}}, in_q.instruction[8:0]};
  assign off6  = {{10{in_q.instruction[5]}}, in_q.instruction[5:0]};
  assign off11 = {{5{in_q.instruction[10]}}, in_q.instruction[10:0]};
  assign imm5  = {{11{in_q.instruction[4]}}, in_q.instruction[4:0]};
  assign r6v   = regs_q[in_q.instruction[8:6]];
  assign r9v   = regs_q[in_q.instruction[11:9]];
  assign src2  = in_q.instruction[5] ? imm5 : regs_q[in_q.instruction[2:0]];

  // Shared ALU operand selection for the exec step.
  logic [1:0]  alu_op;
  logic [15:0] alu_a, alu_b, alu_y;
  always_comb begin
    alu_op = AluAdd;
    alu_a  = pc_q + 16'd1;
    alu_b  = off9;
    unique case (op)
      OpAdd:          begin alu_a = r6v; alu_b = src2; end
      OpAnd:          begin alu_op = AluAnd; alu_a = r6v; alu_b = src2; end
      OpNot:          begin alu_op = AluNot; alu_a = r6v; end
      OpLdr, OpStr:   begin alu_a = r6v; alu_b = off6; end
      OpJsr:          begin
        if (!in_q.instruction[11]) begin alu_op = AluPass; alu_b = r6v; end
        else alu_b = off11;
      end
      OpJmp:          begin alu_op = AluPass; alu_b = r6v; end
      default:        ;
    endcase
  end

  lc3_alu u_alu (.op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .y_o(alu_y));

  // The PC takes the ALU result on a taken branch, a jump or a subroutine call.
  logic pc_jump;
  assign pc_jump = (op == OpBr && (in_q.instruction[11:9] & cc_q) != 3'd0) ||
                   op == OpJmp || op == OpJsr;

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_q[MemAddrBits-1:0];
    mem_wdata = r9v;
    if (state_q == StFinish && res_q.mem_write_valid) begin
      mem_we   = 1'b1;
      mem_wdata = res_q.mem_write_data;
    end
  end

  assign in_if.ready  = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut);
  assign out_if.data  = res_q;

  // Sequencer, architectural state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_q    <= '0;
      cc_q    <= CondZero;
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_if.valid) begin
            in_q    <= in_if.data;
            addr_q  <= in_if.data.address;
            res_q   <= '0;
            state_q <= StExec;
          end
        end
        StExec: begin
          unique case (in_q.mode)
            ModeMemWrite: begin
              res_q.mem_write_valid <= 1'b1;
              res_q.mem_write_addr  <= 16'(addr_q[MemAddrBits-1:0]);
              res_q.mem_write_data  <= in_q.write_data;
              state_q <= StFinish;
            end
            ModeRegWrite: begin
              if (in_q.reg_index < RegIndexPc) begin
                res_q.dest_valid <= 1'b1;
                res_q.dest_index <= in_q.reg_index[2:0];
                res_q.dest_value <= in_q.write_data;
              end else if (in_q.reg_index == RegIndexPc) begin
                pc_q <= in_q.write_data;
              end
              state_q <= StFinish;
            end
            ModeMemRead: state_q <= StWait2;
            default: begin
              pc_q <= pc_jump ? alu_y : pc_q + 16'd1;
              addr_q <= alu_y;
              if (op == OpLd || op == OpLdr || op == OpLdi || op == OpSti) begin
                state_q <= StRead1;
              end else begin
                state_q <= StFinish;
              end
              unique case (op)
                OpBr: ;
                OpAdd, OpAnd, OpNot, OpLea: begin
                  res_q.dest_valid <= 1'b1;
                  res_q.dest_index <= in_q.instruction[11:9];
                  res_q.dest_value <= alu_y;
                end
                OpLd, OpLdr, OpLdi, OpSti: ;
                OpSt, OpStr: begin
                  res_q.mem_write_valid <= 1'b1;
                  res_q.mem_write_addr  <= 16'(alu_y[MemAddrBits-1:0]);
                  res_q.mem_write_data  <= r9v;
                end
                OpJmp: ;
                OpJsr: begin
                  res_q.dest_valid <= 1'b1;
                  res_q.dest_index <= 3'd7;
                  res_q.dest_value <= pc_q + 16'd1;
                end
                OpTrap: begin
                  res_q.status      <= StatusTrap;
                  res_q.trap_vector <= in_q.instruction[7:0];
                end
                OpRti, OpRes: res_q.status <= StatusIllegal;
                default: ;
              endcase
            end
          endcase
        end
        StRead1: state_q <= StWait1;
        StWait1: begin
          addr_q <= mem_rdata;
          if (op == OpLdi) state_q <= StRead2;
          else if (op == OpSti) begin
            res_q.mem_write_valid <= 1'b1;
            res_q.mem_write_addr  <= 16'(mem_rdata[MemAddrBits-1:0]);
            res_q.mem_write_data  <= r9v;
            state_q <= StFinish;
          end else begin
            res_q.dest_valid <= 1'b1;
            res_q.dest_index <= in_q.instruction[11:9];
            res_q.dest_value <= mem_rdata;
            state_q <= StFinish;
          end
        end
        StRead2: state_q <= StWait2;
        StWait2: begin
          if (in_q.mode == ModeMemRead) res_q.read_data <= mem_rdata;
          else begin
            res_q.dest_valid <= 1'b1;
            res_q.dest_index <= in_q.instruction[11:9];
            res_q.dest_value <= mem_rdata;
          end
          state_q <= StFinish;
        end
        StFinish: begin
          // Commit register write and flags; the memory write fires here.
          if (res_q.dest_valid) regs_q[res_q.dest_index] <= res_q.dest_value;
          if (in_q.mode == ModeExec && res_q.dest_valid && op != OpJsr) begin
            cc_q <= flags_of(res_q.dest_value);
            res_q.cond_flags <= flags_of(res_q.dest_value);
          end else res_q.cond_flags <= cc_q;
          res_q.next_pc <= pc_q;
          state_q <= StOut;
        end
        StOut: if (out_if.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  `LC3_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_if.valid, !in_if.ready,
    "input taken while result pending")
  `LC3_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, in_if.valid && in_if.ready,
    state_q == StExec, "accepted word not executed")
  `LC3_ASSERT_IMPL(a_flags_onehot, clk_i, rst_ni, 1'b1, $onehot(cc_q),
    "condition code not one-hot")

endmodule

`default_nettype wire

>>> rtl/core/lc3_mem.sv
// ----------------------------------------------------------------------------
// lc3_mem
// Single-port word memory with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lc3_mem #(
  parameter int unsigned MemAddrBits = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [MemAddrBits-1:0] addr_i,
  input  wire logic [15:0]            wdata_i,
  output      logic [15:0]            rdata_o
);

  logic [15:0] mem_q [2**MemAddrBits];

  // One access a cycle: a registered read, with a write when we_i is high.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/lc3_alu.sv
// ----------------------------------------------------------------------------
// lc3_alu
// Shared 16-bit adder and logic unit used by the exec step of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lc3_alu import lc3_pkg::*; (
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] a_i,
  input  wire logic [15:0] b_i,
  output      logic [15:0] y_o
);

  // Operation select.
  always_comb begin
    unique case (op_i)
      AluAdd:  y_o = a_i + b_i;
      AluAnd:  y_o = a_i & b_i;
      AluNot:  y_o = ~a_i;
      AluPass: y_o = b_i;
      default: y_o = b_i;
    endcase
  end

endmodule

`default_nettype wire

>>> verif/lc3_checker.sv
// ----------------------------------------------------------------------------
// LC-3 execute result checker
// Watches the input and output channels of the execute block. It keeps its
// own copy of the registers, PC, condition code and memory, predicts the
// result of each accepted word, and compares the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lc3_checker import lc3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned words_seen_o
);

  logic [15:0] gpr_q [8];
  logic [15:0] pc_q;
  logic [2:0]  nzp_q;
  logic [15:0] mem_q [logic [15:0]];
  out_word_t   expected_results [$];

  function automatic logic [15:0] sext_bits(input logic [15:0] v, input int bits);
    logic [15:0] r;
    r = v;
    for (int b = bits; b < 16; b++) r[b] = v[bits-1];
    return r;
  endfunction

  function automatic logic [15:0] peek_word(input logic [15:0] a);
    if (mem_q.exists(a)) return mem_q[a];
    return 16'd0;
  endfunction

  function automatic logic [2:0] nzp_of(input logic [15:0] v);
    if (v[15]) return 3'b100;
    if (v == 16'd0) return 3'b010;
    return 3'b001;
  endfunction

  // Advance the architectural state by one word and return its result.
  function automatic out_word_t execute_word(input in_word_t w);
    out_word_t   r;
    logic [3:0]  op;
    logic [2:0]  r9, r6;
    logic [15:0] off9, off6, src2, pc;
    r = '0;
    case (w.mode)
      ModeMemWrite: begin
        r.mem_write_valid = 1'b1;
        r.mem_write_addr  = w.address;
        r.mem_write_data  = w.write_data;
      end
      ModeRegWrite: begin
        if (w.reg_index < RegIndexPc) begin
          r.dest_valid = 1'b1;
          r.dest_index = w.reg_index[2:0];
          r.dest_value = w.write_data;
        end else if (w.reg_index == RegIndexPc) begin
          pc_q = w.write_data;
        end
      end
      ModeMemRead: r.read_data = peek_word(w.address);
      default: begin
        op   = w.instruction[15:12];
        r9   = w.instruction[11:9];
        r6   = w.instruction[8:6];
        off9 = sext_bits(w.instruction, 9);
        off6 = sext_bits(w.instruction, 6);
        src2 = w.instruction[5] ? sext_bits(w.instruction, 5) : gpr_q[w.instruction[2:0]];
        pc_q = pc_q + 16'd1;
        pc   = pc_q;
        case (op)
          OpBr: if ((r9 & nzp_q) != 3'b000) pc_q = pc + off9;
          OpAdd: begin
            r.dest_valid = 1'b1; r.dest_index = r9; r.dest_value = gpr_q[r6] + src2;
          end
          OpAnd: begin
            r.dest_valid = 1'b1; r.dest_index = r9; r.dest_value = gpr_q[r6] & src2;
          end
          OpNot: begin
            r.dest_valid = 1'b1; r.dest_index = r9; r.dest_value = ~gpr_q[r6];
          end
          OpLd: begin
            r.dest_valid = 1'b1; r.dest_index = r9; r.dest_value = peek_word(pc + off9);
          end
          OpLdi: begin
            r.dest_valid = 1'b1; r.dest_index = r9;
            r.dest_value = peek_word(peek_word(pc + off9));
          end
          OpLdr: begin
            r.dest_valid = 1'b1; r.dest_index = r9;
            r.dest_value = peek_word(gpr_q[r6] + off6);
          end
          OpLea: begin
            r.dest_valid = 1'b1; r.dest_index = r9; r.dest_value = pc + off9;
          end
          OpSt: begin
            r.mem_write_valid = 1'b1; r.mem_write_addr = pc + off9;
            r.mem_write_data = gpr_q[r9];
          end
          OpSti: begin
            r.mem_write_valid = 1'b1; r.mem_write_addr = peek_word(pc + off9);
            r.mem_write_data = gpr_q[r9];
          end
          OpStr: begin
            r.mem_write_valid = 1'b1; r.mem_write_addr = gpr_q[r6] + off6;
            r.mem_write_data = gpr_q[r9];
          end
          OpJmp: pc_q = gpr_q[r6];
          OpJsr: begin
            // The jump target is taken before R7 is overwritten.
            if (w.instruction[11]) pc_q = pc + sext_bits(w.instruction, 11);
            else pc_q = gpr_q[r6];
            r.dest_valid = 1'b1; r.dest_index = 3'd7; r.dest_value = pc;
          end
          OpTrap: begin
            r.status = StatusTrap; r.trap_vector = w.instruction[7:0];
          end
          default: r.status = StatusIllegal;
        endcase
        if (r.dest_valid && op != OpJsr) nzp_q = nzp_of(r.dest_value);
      end
    endcase
    if (r.dest_valid) gpr_q[r.dest_index] = r.dest_value;
    if (r.mem_write_valid) mem_q[r.mem_write_addr] = r.mem_write_data;
    r.cond_flags = nzp_q;
    r.next_pc    = pc_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) gpr_q[i] = '0;
      pc_q = '0;
      nzp_q = CondZero;
      mem_q.delete();
      expected_results.delete();
      fail_count_o = 0;
      words_seen_o = 0;
    end else begin
      // Compare the result before predicting the next word.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("Result word with no expectation pending");
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", 16'(e.status), 16'(out_data_i.status));
          check_field("dest_valid", 16'(e.dest_valid), 16'(out_data_i.dest_valid));
          check_field("dest_index", 16'(e.dest_index), 16'(out_data_i.dest_index));
          check_field("dest_value", e.dest_value, out_data_i.dest_value);
          check_field("cond_flags", 16'(e.cond_flags), 16'(out_data_i.cond_flags));
          check_field("next_pc", e.next_pc, out_data_i.next_pc);
          check_field("mem_write_valid", 16'(e.mem_write_valid),
                      16'(out_data_i.mem_write_valid));
          check_field("mem_write_addr", e.mem_write_addr, out_data_i.mem_write_addr);
          check_field("mem_write_data", e.mem_write_data, out_data_i.mem_write_data);
          check_field("trap_vector", 16'(e.trap_vector), 16'(out_data_i.trap_vector));
          check_field("read_data", e.read_data, out_data_i.read_data);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(execute_word(in_data_i));
        words_seen_o++;
      end
    end
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// LC-3 execute block testbench
// Drives directed and random words into the execute block under several
// idle and stall patterns. The checker beside the block predicts and
// compares every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lc3_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  int unsigned fail_count, pending, words_seen, stall_pct, idle_cycles;
  bit timed_out;
  logic [15:0] written_addrs [$];

  lc3_in_if  in_ch ();
  lc3_out_if out_ch ();

  lc3_instruction_execute i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  lc3_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .words_seen_o (words_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver stalls at the chosen rate, redrawn each falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles with no word accepted on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        timed_out = 1'b1;
        $display("Watchdog stopped the run after %0d words with %0d results pending.",
                 words_seen, pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Pick an address already written so that no unwritten word is read.
  function automatic logic [15:0] known_addr();
    return written_addrs[$urandom_range(written_addrs.size() - 1)];
  endfunction

  // Valid stays high into the next word when there is no idle gap.
  task automatic send_word(input in_word_t w, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (w.mode == ModeMemWrite) written_addrs.push_back(w.address);
  endtask

  task automatic store_word(input logic [15:0] a, input logic [15:0] d,
                            input int unsigned ip);
    in_word_t w;
    w = '0;
    w.mode = ModeMemWrite; w.address = a; w.write_data = d;
    w.instruction = 16'($urandom); w.reg_index = 4'($urandom);
    send_word(w, ip);
  endtask

  task automatic reg_write(input logic [3:0] idx, input logic [15:0] d, input int unsigned ip);
    in_word_t w;
    w = '0;
    w.mode = ModeRegWrite; w.reg_index = idx; w.write_data = d;
    w.instruction = 16'($urandom); w.address = 16'($urandom);
    send_word(w, ip);
  endtask

  task automatic exec_word(input logic [15:0] ins, input int unsigned ip);
    in_word_t w;
    w = '0;
    w.mode = ModeExec; w.instruction = ins;
    w.address = 16'($urandom); w.write_data = 16'($urandom); w.reg_index = 4'($urandom);
    send_word(w, ip);
  endtask

  // Memory reads by loads go through the pointer in a register or the PC
  // offset, so the random part makes those targets written first.
  task automatic random_word(input int unsigned ip);
    logic [15:0] ins, a;
    logic [3:0]  op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      store_word(16'($urandom), 16'($urandom), ip);
    end else if (pick < 20) begin
      reg_write(4'($urandom_range(15)), 16'($urandom), ip);
    end else if (pick < 26) begin
      in_word_t w;
      w = '0;
      w.mode = ModeMemRead; w.address = known_addr();
      w.instruction = 16'($urandom); w.write_data = 16'($urandom);
      w.reg_index = 4'($urandom);
      send_word(w, ip);
    end else begin
      ins = 16'($urandom);
      op  = ins[15:12];
      if (op == OpLd || op == OpLdi || op == OpSti) begin
        // Pin the PC, fill the target word and for indirection its pointer.
        a = 16'($urandom);
        reg_write(RegIndexPc, a, ip);
        a = a + 16'd1 + {{7{ins[8]}}, ins[8:0]};
        store_word(a, (op == OpLd) ? 16'($urandom) : known_addr(), ip);
      end else if (op == OpLdr) begin
        a = known_addr();
        reg_write({1'b0, ins[8:6]}, a - {{10{ins[5]}}, ins[5:0]}, ip);
      end
      exec_word(ins, ip);
    end
  endtask

  initial begin
    in_word_t w;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    stall_pct    = 0;
    idle_cycles  = 0;
    timed_out    = 1'b0;
    rst_ni       = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every opcode and the corner cases.
    store_word(16'h0000, 16'h0000, 0);
    store_word(16'hFFFF, 16'hFFFF, 0);
    store_word(16'h0002, 16'hFFFF, 0);
    reg_write(4'd7, 16'hFFFF, 0);
    reg_write(4'd0, 16'h8000, 0);
    reg_write(4'd15, 16'h1234, 0);
    reg_write(RegIndexPc, 16'hFFFF, 0);
    exec_word({OpAdd, 3'd1, 3'd7, 1'b1, 5'h0F}, 0);
    exec_word({OpAnd, 3'd2, 3'd7, 1'b0, 2'b00, 3'd0}, 0);
    exec_word({OpNot, 3'd3, 3'd0, 6'h3F}, 0);
    exec_word({OpBr, 3'b000, 9'h1FF}, 0);
    exec_word({OpBr, 3'b111, 9'h100}, 0);
    exec_word({OpLea, 3'd4, 9'h0FF}, 0);
    exec_word({OpJmp, 3'd0, 3'd7, 6'd0}, 0);
    exec_word({OpJsr, 1'b0, 2'd0, 3'd7, 6'd0}, 0);
    exec_word({OpJsr, 1'b1, 11'h7FF}, 0);
    reg_write(RegIndexPc, 16'hFFFF, 0);
    exec_word({OpLd, 3'd5, 9'h000}, 0);
    exec_word({OpLdi, 3'd6, 9'h1FF}, 0);
    exec_word({OpSt, 3'd7, 9'h1FF}, 0);
    exec_word({OpSti, 3'd6, 9'h1FF}, 0);
    exec_word({OpStr, 3'd7, 3'd0, 6'h20}, 0);
    exec_word({OpLdr, 3'd1, 3'd0, 6'h20}, 0);
    exec_word({OpRti, 12'hFFF}, 0);
    exec_word({OpRes, 12'h000}, 0);
    exec_word({OpTrap, 4'h0, 8'hFF}, 0);
    w = '1;
    w.mode = ModeMemRead; w.address = 16'hFFFF;
    send_word(w, 0);

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      stall_pct = (ph == 2) ? 88 : (ph == 3) ? 36 : 0;
      for (int n = 0; n < 130; n++) begin
        random_word((ph == 1) ? 88 : (ph == 3) ? 36 : 0);
        if (timed_out) break;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0 && !timed_out) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d words through all four modes and every opcode", words_seen);
    $display("under no idling, sender gaps, receiver stalls and both together.");
    if (timed_out) begin
      $display("Test completed with failures");
    end else if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/lc3_pkg.sv
rtl/core/lc3_if.sv
rtl/core/lc3_mem.sv
rtl/core/lc3_alu.sv
rtl/core/lc3_instruction_execute.sv
verif/lc3_checker.sv
verif/testbench.sv
